>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh: assertion macros shared by the RGB-to-CIELAB core.
// Each macro checks on the rising edge and is off while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rgb2lab: invariant violated");

// Check that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb2lab: implication violated");

`endif

>>> rtl/core/rgb2lab_pkg.sv
// ----------------------------------------------------------------------------
// rgb2lab_pkg: shared types and constants of the RGB-to-CIELAB core.
// Pixel structs, sRGB-to-XYZ matrix scaled by 1e7, D65 white divisors and
// the fixed constants of the CIELAB transfer and encoding.
// ----------------------------------------------------------------------------
package rgb2lab_pkg;

  localparam int CH_W   = 8;
  localparam int COEF_W = 24;
  localparam int SUM_W  = 32;
  localparam int DEN_W  = 32;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_pixel_t;

  typedef struct packed {
    logic [6:0] lightness;
    logic [7:0] green_red;
    logic [7:0] blue_yellow;
  } out_pixel_t;

  // sRGB-to-XYZ matrix, coefficients times 1e7
  localparam logic [COEF_W-1:0] MAT_COEF [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  // 255 times the D65 white point, times 1e7
  localparam logic [DEN_W-1:0] WHITE_DEN [3] = '{
    32'd2423698500, 32'd2550000000, 32'd2776516500
  };

  // Knee of the transfer function: 8856 / 1e6
  localparam int EPS_NUM = 8856;
  localparam int EPS_DEN = 1000000;

  // Linear segment: (9033 t + 160) / 1160
  localparam int LIN_MUL = 9033;
  localparam int LIN_OFF = 160;
  localparam int LIN_DIV = 1160;

  // Output encoding
  localparam int L_MUL  = 116;
  localparam int L_OFF  = 16;
  localparam int A_MUL  = 500;
  localparam int B_MUL  = 200;
  localparam int AB_OFF = 128;
  localparam int L_TOP  = 127;
  localparam int AB_TOP = 255;

  // Pipeline depth of the front and back ends
  localparam int XYZ_STAGES = 4;
  localparam int ENC_STAGES = 2;

endpackage

>>> rtl/core/rgb_to_lab_pixel_top.sv
// ----------------------------------------------------------------------------
// rgb_to_lab_pixel_top: 8-bit RGB pixel to encoded CIELAB pixel, D65 white.
// The cube-root pipeline of each lane resolves one result bit per stage.
// One item per cycle while busy is low.
// Reset clears all valid bits, busy is high through reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_lab_pixel_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  rgb2lab_pkg::in_pixel_t  in_pixel,
  output logic                    out_valid,
  output rgb2lab_pkg::out_pixel_t out_pixel
);

  localparam int LAT = rgb2lab_pkg::XYZ_STAGES + FRAC_BITS + 1
                     + rgb2lab_pkg::ENC_STAGES;

  logic                     busy_r;
  logic                     accept;
  logic                     xyz_v;
  logic [2:0][FRAC_BITS:0]  xyz_t;
  logic [2:0]               lane_v;
  logic [2:0][FRAC_BITS:0]  lane_f;

  // Hold off items during reset and the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  rgb2lab_xyz #(
    .FRAC_BITS (FRAC_BITS)
  ) u_xyz (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_pixel  (in_pixel),
    .out_valid (xyz_v),
    .out_t     (xyz_t)
  );

  // One transfer-function lane per channel
  for (genvar i = 0; i < 3; i++) begin : g_lane
    rgb2lab_f #(
      .FRAC_BITS (FRAC_BITS)
    ) u_f (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (xyz_v),
      .in_t      (xyz_t[i]),
      .out_valid (lane_v[i]),
      .out_f     (lane_f[i])
    );
  end

  rgb2lab_enc #(
    .FRAC_BITS (FRAC_BITS)
  ) u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (&lane_v),
    .fx        (lane_f[0]),
    .fy        (lane_f[1]),
    .fz        (lane_f[2]),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  // Lanes run in lockstep
  `ASSERT_ALWAYS(a_lane_sync, clk, rst_n, (lane_v == 3'b000) || (lane_v == 3'b111))
  // Every result traces back to an item taken by the block
  `ASSERT_IMPLY(a_out_latency, clk, rst_n, out_valid, $past(accept, LAT))
  // Lightness never passes 100
  `ASSERT_IMPLY(a_light_range, clk, rst_n, out_valid, out_pixel.lightness <= 7'd100)

endmodule

>>> rtl/core/rgb2lab_xyz.sv
// ----------------------------------------------------------------------------
// rgb2lab_xyz: matrix multiply and white-point scaling.
// Four stages: matrix sums, reciprocal estimate, back-multiply, correction.
// Output is t = floor(S * 2^F / DEN) per channel, exact.
// ----------------------------------------------------------------------------
module rgb2lab_xyz #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  rgb2lab_pkg::in_pixel_t        in_pixel,
  output logic                          out_valid,
  output logic [2:0][FRAC_BITS:0]       out_t
);

  localparam int TW = FRAC_BITS + 1;
  localparam int SW = rgb2lab_pkg::SUM_W;
  localparam int PW = SW + TW;

  // Reciprocals floor(2^(32+F) / DEN); error of the estimate stays below one
  localparam logic [TW-1:0] RECIP [3] = '{
    TW'((64'd1 << (SW + FRAC_BITS)) / 64'(rgb2lab_pkg::WHITE_DEN[0])),
    TW'((64'd1 << (SW + FRAC_BITS)) / 64'(rgb2lab_pkg::WHITE_DEN[1])),
    TW'((64'd1 << (SW + FRAC_BITS)) / 64'(rgb2lab_pkg::WHITE_DEN[2]))
  };

  logic [2:0][rgb2lab_pkg::CH_W-1:0] ch;
  logic [2:0][SW-1:0]                sum_nxt;
  logic [2:0][TW-1:0]                q_nxt;
  logic [2:0][PW-1:0]                p_nxt;
  logic [2:0][TW-1:0]                t_nxt;

  logic                a_v_r, b_v_r, c_v_r, d_v_r;
  logic [2:0][SW-1:0]  a_sum_r, b_sum_r, c_sum_r;
  logic [2:0][TW-1:0]  b_q_r, c_q_r;
  logic [2:0][PW-1:0]  c_p_r;
  logic [2:0][TW-1:0]  d_t_r;

  assign ch[0] = in_pixel.red;
  assign ch[1] = in_pixel.green;
  assign ch[2] = in_pixel.blue;

  // Stage A: matrix sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = '0;
      for (int j = 0; j < 3; j++) begin
        sum_nxt[i] = sum_nxt[i] + SW'(rgb2lab_pkg::MAT_COEF[i][j]) * SW'(ch[j]);
      end
    end
  end

  // Stage B: quotient estimate, low by at most one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = TW'((PW'(a_sum_r[i]) * PW'(RECIP[i])) >> SW);
    end
  end

  // Stage C: multiply the estimate back
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = PW'(b_q_r[i]) * PW'(rgb2lab_pkg::WHITE_DEN[i]);
    end
  end

  // Stage D: bump the estimate when the remainder reaches the divisor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_nxt[i] = c_q_r[i] + TW'(((PW'(c_sum_r[i]) << FRAC_BITS) - c_p_r[i])
                                >= PW'(rgb2lab_pkg::WHITE_DEN[i]));
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    a_sum_r <= sum_nxt;
    b_sum_r <= a_sum_r;
    b_q_r   <= q_nxt;
    c_sum_r <= b_sum_r;
    c_q_r   <= b_q_r;
    c_p_r   <= p_nxt;
    d_t_r   <= t_nxt;
  end

  assign out_valid = d_v_r;
  assign out_t     = d_t_r;

endmodule

>>> rtl/core/rgb2lab_f.sv
// ----------------------------------------------------------------------------
// rgb2lab_f: CIELAB transfer function for one channel.
// Cube root found one result bit per stage, with square and cube kept
// incrementally; the linear segment runs alongside and is picked at the end.
// ----------------------------------------------------------------------------
module rgb2lab_f #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [FRAC_BITS:0] in_t,
  output logic               out_valid,
  output logic [FRAC_BITS:0] out_f
);

  localparam int TW  = FRAC_BITS + 1;
  localparam int NS  = FRAC_BITS + 1;
  localparam int C2W = 2 * FRAC_BITS + 1;
  localparam int C3W = 3 * FRAC_BITS + 1;
  localparam int SQW = 2 * FRAC_BITS + 3;
  localparam int XW  = 3 * FRAC_BITS + 4;

  localparam logic [63:0] EPS =
    (64'(rgb2lab_pkg::EPS_NUM) << FRAC_BITS) / 64'(rgb2lab_pkg::EPS_DEN);
  localparam int EW = $clog2(EPS + 64'd1);
  localparam logic [63:0] NMAX =
    64'(rgb2lab_pkg::LIN_MUL) * EPS + (64'(rgb2lab_pkg::LIN_OFF) << FRAC_BITS);
  localparam int NW = $clog2(NMAX + 64'd1);
  localparam logic [63:0] RECIP = (64'd1 << NW) / 64'(rgb2lab_pkg::LIN_DIV);
  localparam int RW = $clog2(RECIP + 64'd1);

  // Cube-root pipeline state, one entry per stage; square, cube and t skip the last
  logic [TW-1:0]  c_r  [NS];
  logic [C2W-1:0] c2_r [FRAC_BITS];
  logic [C3W-1:0] c3_r [FRAC_BITS];
  logic [TW-1:0]  t_r  [FRAC_BITS];
  logic           gt_r [NS];
  logic           v_r  [NS];

  // Linear segment pipeline
  logic [NW-1:0] n_nxt;
  logic [TW-1:0] lq_nxt;
  logic [NW-1:0] lp_nxt;
  logic [TW-1:0] lf_nxt;
  logic [NW-1:0] l0_n_r, l1_n_r, l2_n_r;
  logic [TW-1:0] l1_q_r, l2_q_r;
  logic [NW-1:0] l2_p_r;
  logic [TW-1:0] lf_r [3:FRAC_BITS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = FRAC_BITS - k;

    logic [TW-1:0]  c_in;
    logic [C2W-1:0] c2_in;
    logic [C3W-1:0] c3_in;
    logic [TW-1:0]  t_in;
    logic           gt_in;
    logic [XW-1:0]  cand3;
    logic [SQW-1:0] cand2;
    logic [XW-1:0]  target;
    logic           fit;

    if (k == 0) begin : g_first
      assign c_in  = '0;
      assign c2_in = '0;
      assign c3_in = '0;
      assign t_in  = in_t;
      assign gt_in = in_t > TW'(EPS);
    end else begin : g_next
      assign c_in  = c_r[k-1];
      assign c2_in = c2_r[k-1];
      assign c3_in = c3_r[k-1];
      assign t_in  = t_r[k-1];
      assign gt_in = gt_r[k-1];
    end

    // (c + 2^B)^3 and (c + 2^B)^2 from the running values
    assign cand3 = XW'(c3_in)
                 + (((XW'(c2_in) << 1) + XW'(c2_in)) << B)
                 + (((XW'(c_in) << 1) + XW'(c_in)) << (2 * B))
                 + (XW'(1) << (3 * B));
    assign cand2 = SQW'(c2_in) + (SQW'(c_in) << (B + 1)) + (SQW'(1) << (2 * B));
    assign target = XW'(t_in) << (2 * FRAC_BITS);
    assign fit    = cand3 <= target;

    // Keep the bit when the cube stays within t * 2^(2F)
    always_ff @(posedge clk) begin
      c_r[k]  <= fit ? (c_in | (TW'(1) << B)) : c_in;
      gt_r[k] <= gt_in;
    end

    if (k < FRAC_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        c2_r[k] <= fit ? C2W'(cand2) : c2_in;
        c3_r[k] <= fit ? C3W'(cand3) : c3_in;
        t_r[k]  <= t_in;
      end
    end
  end

  // Linear segment: N = 9033 t + 160 * 2^F, then N / 1160 by reciprocal
  assign n_nxt  = NW'(rgb2lab_pkg::LIN_MUL) * NW'(in_t[EW-1:0])
                + (NW'(rgb2lab_pkg::LIN_OFF) << FRAC_BITS);
  assign lq_nxt = TW'(((NW + RW)'(l0_n_r) * (NW + RW)'(RECIP)) >> NW);
  assign lp_nxt = NW'(l1_q_r) * NW'(rgb2lab_pkg::LIN_DIV);
  assign lf_nxt = l2_q_r + TW'((l2_n_r - l2_p_r) >= NW'(rgb2lab_pkg::LIN_DIV));

  always_ff @(posedge clk) begin
    l0_n_r <= n_nxt;
    l1_n_r <= l0_n_r;
    l1_q_r <= lq_nxt;
    l2_n_r <= l1_n_r;
    l2_q_r <= l1_q_r;
    l2_p_r <= lp_nxt;
    lf_r[3] <= lf_nxt;
    for (int k = 4; k <= FRAC_BITS; k++) begin
      lf_r[k] <= lf_r[k-1];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // Pick the cube root above the knee, the line at or below it
  assign out_f     = gt_r[NS-1] ? c_r[NS-1] : lf_r[FRAC_BITS];
  assign out_valid = v_r[NS-1];

endmodule

>>> rtl/core/rgb2lab_enc.sv
// ----------------------------------------------------------------------------
// rgb2lab_enc: L*, a*, b* from the transfer values, clamped to bytes.
// Stage one forms the scaled sums, stage two clamps and truncates.
// ----------------------------------------------------------------------------
module rgb2lab_enc #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [FRAC_BITS:0]      fx,
  input  logic [FRAC_BITS:0]      fy,
  input  logic [FRAC_BITS:0]      fz,
  output logic                    out_valid,
  output rgb2lab_pkg::out_pixel_t out_pixel
);

  localparam int VW = FRAC_BITS + 11;
  localparam int QW = VW - 1 - FRAC_BITS;

  localparam logic signed [VW-1:0] L_MUL_S = VW'(rgb2lab_pkg::L_MUL);
  localparam logic signed [VW-1:0] A_MUL_S = VW'(rgb2lab_pkg::A_MUL);
  localparam logic signed [VW-1:0] B_MUL_S = VW'(rgb2lab_pkg::B_MUL);
  localparam logic signed [VW-1:0] L_OFF_S = VW'(rgb2lab_pkg::L_OFF) << FRAC_BITS;
  localparam logic signed [VW-1:0] AB_OFF_S = VW'(rgb2lab_pkg::AB_OFF) << FRAC_BITS;

  logic signed [VW-1:0] sx, sy, sz;
  logic signed [VW-1:0] lv_nxt, av_nxt, bv_nxt;
  logic signed [VW-1:0] lv_r, av_r, bv_r;
  logic                 v1_r, v2_r;
  logic [7:0]           l_byte;
  rgb2lab_pkg::out_pixel_t pix_nxt, pix_r;

  // Drop negatives to zero, take the integer part, saturate at top
  function automatic logic [7:0] to_byte(logic signed [VW-1:0] v, logic [7:0] top);
    logic [QW-1:0] q;
    q = v[VW-2:FRAC_BITS];
    if (v < 0) begin
      return 8'd0;
    end else if (q > QW'(top)) begin
      return top;
    end else begin
      return q[7:0];
    end
  endfunction

  assign sx = VW'($signed({1'b0, fx}));
  assign sy = VW'($signed({1'b0, fy}));
  assign sz = VW'($signed({1'b0, fz}));

  // Stage one: scaled sums
  assign lv_nxt = sy * L_MUL_S - L_OFF_S;
  assign av_nxt = (sx - sy) * A_MUL_S + AB_OFF_S;
  assign bv_nxt = (sy - sz) * B_MUL_S + AB_OFF_S;

  // Stage two: clamp to bytes
  assign l_byte              = to_byte(lv_r, 8'(rgb2lab_pkg::L_TOP));
  assign pix_nxt.lightness   = l_byte[6:0];
  assign pix_nxt.green_red   = to_byte(av_r, 8'(rgb2lab_pkg::AB_TOP));
  assign pix_nxt.blue_yellow = to_byte(bv_r, 8'(rgb2lab_pkg::AB_TOP));

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    lv_r  <= lv_nxt;
    av_r  <= av_nxt;
    bv_r  <= bv_nxt;
    pix_r <= pix_nxt;
  end

  assign out_valid = v2_r;
  assign out_pixel = pix_r;

endmodule

>>> tb/sv/lab_pixel_checker.sv
// ----------------------------------------------------------------------------
// lab_pixel_checker: predicts and checks the RGB-to-CIELAB pixel results.
// Watches the command and result channels of rgb_to_lab_pixel_top. For each
// accepted pixel it computes the encoded Lab pixel in the block's fixed-point
// format and queues it. Each result strobe is then compared field by field
// against the oldest queued pixel.
// ----------------------------------------------------------------------------
module lab_pixel_checker
  import rgb2lab_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_pixel_t  in_pixel,
  input  logic       out_valid,
  input  out_pixel_t out_pixel,
  input  logic       run_done,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output int         clamp_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  // sRGB-to-XYZ matrix times 1e7, and 255 times the D65 white times 1e7
  localparam logic [63:0] RGB_TO_XYZ [3][3] = '{
    '{64'd4124564, 64'd3575761, 64'd1804375},
    '{64'd2126729, 64'd7151522, 64'd721750},
    '{64'd193339,  64'd1191920, 64'd9503041}
  };
  localparam logic [63:0] WHITE_SCALE [3] = '{
    64'd2423698500, 64'd2550000000, 64'd2776516500
  };

  typedef struct {
    in_pixel_t  rgb;
    out_pixel_t lab;
  } lab_due_t;

  lab_due_t   lab_due [$];
  lab_due_t   oldest;
  int         bad_count = 0;

  // Largest c with c^3 <= t * 2^(2F), one result bit at a time
  function automatic logic [63:0] cube_root_q(logic [63:0] t);
    logic [127:0] target;
    logic [127:0] root;
    logic [127:0] cand;
    target = {64'd0, t} << (2 * FRAC_BITS);
    root   = '0;
    for (int bitpos = FRAC_BITS; bitpos >= 0; bitpos--) begin
      cand = root | (128'd1 << bitpos);
      if (cand * cand * cand <= target) begin
        root = cand;
      end
    end
    return root[63:0];
  endfunction

  // CIELAB transfer: cube root above the knee, linear segment at or below it
  function automatic logic [63:0] lab_transfer(logic [63:0] t);
    logic [63:0] knee;
    knee = (64'd8856 << FRAC_BITS) / 64'd1000000;
    if (t > knee) begin
      return cube_root_q(t);
    end
    return (64'd9033 * t + (64'd160 << FRAC_BITS)) / 64'd1160;
  endfunction

  // Drop the fraction, zero below, saturate at the top code
  function automatic logic [7:0] to_code(logic signed [63:0] v, logic [63:0] top);
    logic [63:0] whole;
    if (v < 0) begin
      return 8'd0;
    end
    whole = v;
    whole = whole >> FRAC_BITS;
    return (whole > top) ? top[7:0] : whole[7:0];
  endfunction

  function automatic out_pixel_t lab_of_pixel(in_pixel_t px);
    logic [63:0]        chan [3];
    logic [63:0]        tri_sum;
    logic [63:0]        f_val [3];
    logic signed [63:0] l_val;
    logic signed [63:0] a_val;
    logic signed [63:0] b_val;
    logic [7:0]         l_code;
    out_pixel_t         lab;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    for (int row = 0; row < 3; row++) begin
      tri_sum = '0;
      for (int col = 0; col < 3; col++) begin
        tri_sum += RGB_TO_XYZ[row][col] * chan[col];
      end
      f_val[row] = lab_transfer((tri_sum << FRAC_BITS) / WHITE_SCALE[row]);
    end
    l_val = 64'sd116 * $signed(f_val[1]) - $signed(64'd16 << FRAC_BITS);
    a_val = 64'sd500 * ($signed(f_val[0]) - $signed(f_val[1]))
          + $signed(64'd128 << FRAC_BITS);
    b_val = 64'sd200 * ($signed(f_val[1]) - $signed(f_val[2]))
          + $signed(64'd128 << FRAC_BITS);
    l_code          = to_code(l_val, 64'd127);
    lab.lightness   = l_code[6:0];
    lab.green_red   = to_code(a_val, 64'd255);
    lab.blue_yellow = to_code(b_val, 64'd255);
    return lab;
  endfunction

  task automatic flag_error(string msg);
    bad_count++;
    if (bad_count <= 10) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
  endtask

  // Retire results first, then queue the pixel taken at this edge
  always @(posedge clk) begin
    if (rst_n && $isunknown(out_valid)) begin
      flag_error("out_valid is unknown");
    end
    if (rst_n && out_valid === 1'b1) begin
      if (lab_due.size() == 0) begin
        flag_error($sformatf("unexpected Lab result L=%0d a=%0d b=%0d",
                             out_pixel.lightness, out_pixel.green_red,
                             out_pixel.blue_yellow));
      end else begin
        oldest = lab_due.pop_front();
        checked++;
        if (out_pixel.lightness !== oldest.lab.lightness ||
            out_pixel.green_red !== oldest.lab.green_red ||
            out_pixel.blue_yellow !== oldest.lab.blue_yellow) begin
          flag_error($sformatf(
            "rgb=%02h%02h%02h: want L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
            oldest.rgb.red, oldest.rgb.green, oldest.rgb.blue,
            oldest.lab.lightness, oldest.lab.green_red, oldest.lab.blue_yellow,
            out_pixel.lightness, out_pixel.green_red, out_pixel.blue_yellow));
        end
        if (oldest.lab.lightness == 7'd0 ||
            oldest.lab.green_red inside {8'd0, 8'd255} ||
            oldest.lab.blue_yellow inside {8'd0, 8'd255}) begin
          clamp_hits++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      lab_due.push_back('{rgb: in_pixel, lab: lab_of_pixel(in_pixel)});
    end
    pending = lab_due.size();
  end

  // Report pixels whose results never showed up
  always @(posedge run_done) begin
    if (lab_due.size() != 0) begin
      $display("[%0t] ERROR: %0d Lab results never arrived", $time, lab_due.size());
    end
  end

  assign fail_count = bad_count + (run_done ? pending : 0);

  initial begin
    checked    = 0;
    pending    = 0;
    clamp_hits = 0;
  end

endmodule

>>> tb/sv/rgb_to_lab_pixel_top_test.sv
// ----------------------------------------------------------------------------
// rgb_to_lab_pixel_top_test: stimulus and verdict for the RGB-to-CIELAB core.
// Sends corner pixels and then random pixels, biased toward the dark linear
// segment and the saturated colors, with random idle gaps on the command
// side. A separate checker predicts and compares every Lab result.
// ----------------------------------------------------------------------------
module rgb_to_lab_pixel_top_test;
  import rgb2lab_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC         = 16;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = FRAC + 20;
  localparam int STALL_LIMIT  = 2000;

  // Black, white, primaries, secondaries, near-black and knee pixels
  localparam int CORNER_COUNT = 23;
  localparam logic [23:0] CORNER_RGB [CORNER_COUNT] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010101, 24'h010000,
    24'h000100, 24'h000001, 24'h020202, 24'h030303, 24'h0A0A0A,
    24'h808080, 24'h7F7F7F, 24'h55AA55, 24'hAA55AA, 24'h030405,
    24'hFE0101, 24'h01FEFE, 24'hFF80FF
  };

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       start    = 1'b0;
  in_pixel_t  in_pixel = '0;
  logic       run_done = 1'b0;
  logic       busy;
  logic       out_valid;
  out_pixel_t out_pixel;
  int         fail_count;
  int         pending;
  int         checked;
  int         clamp_hits;
  int         sent     = 0;
  int         stall_cnt = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rgb_to_lab_pixel_top #(
    .FRAC_BITS (FRAC)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  lab_pixel_checker #(
    .FRAC_BITS (FRAC)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_pixel  (out_pixel),
    .run_done   (run_done),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .clamp_hits (clamp_hits)
  );

  // Hold the item until the block takes it
  task automatic push_pixel(in_pixel_t px);
    start    <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Idle the command side about 23 percent of the time
  task automatic maybe_idle(bit allow);
    while (allow && $urandom_range(0, 99) < 23) begin
      start    <= 1'b0;
      in_pixel <= in_pixel_t'(24'($urandom()));
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_channel(int mode);
    case (mode)
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(0, 12));
      2:       return 8'($urandom_range(240, 255));
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  function automatic in_pixel_t random_pixel();
    int        roll;
    int        mode;
    in_pixel_t px;
    roll = $urandom_range(0, 99);
    mode = (roll < 60) ? 0 : (roll < 80) ? 1 : (roll < 90) ? 2 : 3;
    px.red   = pick_channel(mode);
    px.green = pick_channel(mode);
    px.blue  = pick_channel(mode);
    return px;
  endfunction

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cnt);
      $display("rgb_to_lab_pixel_top verification failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    for (int idx = 0; idx < CORNER_COUNT; idx++) begin
      maybe_idle(1'b1);
      push_pixel(in_pixel_t'(CORNER_RGB[idx]));
    end

    // Random pixels, back to back through the middle stretch
    for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
      maybe_idle(idx < 500 || idx >= 800);
      push_pixel(random_pixel());
    end
    start <= 1'b0;

    // Drain the pipeline, then give it time to misbehave
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Ran %0d pixels (%0d corner cases), %0d Lab results checked,",
             sent, CORNER_COUNT, checked);
    $display("%0d of them with a clamped channel", clamp_hits);
    if (fail_count == 0) begin
      $display("rgb_to_lab_pixel_top verification clean");
    end else begin
      $display("rgb_to_lab_pixel_top verification failed");
    end
    $finish;
  end

endmodule
